// File: rtl/scan_point_line_clustering_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scan point line clustering block
// Implication checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SCAN_POINT_LINE_CLUSTERING_ASSERT_SVH
`define SCAN_POINT_LINE_CLUSTERING_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SPLC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SPLC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/splc_pkg.sv
// ----------------------------------------------------------------------------
// splc_pkg
// Shared types, constants and the microcode program of the line clustering
// sequencer.
// ----------------------------------------------------------------------------
package splc_pkg;

    // Widths and defaults
    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int DIGIT_W        = 8;
    localparam int QSQ_W          = 2 * CFG_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SIM   = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] MAX_GAP_RST    = 16'd500;
    localparam logic [CFG_W-1:0] ANGLE_GATE_RST = 16'd50;
    localparam logic [CFG_W-1:0] LINE_SIM_RST   = 16'd58982;

    // Step holds: the step repeats while its hold condition is true
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_NO_INPUT,
        HOLD_MUL_BUSY,
        HOLD_OUT_FULL
    } hold_t;

    // Datapath actions, one per step
    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_MAC_DXDX,
        OP_MAC_DYDY,
        OP_MAC_LXLX,
        OP_MAC_LYLY,
        OP_MAC_LXDX,
        OP_MAC_LYDY,
        OP_SAVE_DSQ,
        OP_SAVE_LSQ,
        OP_SAVE_ADOT,
        OP_MUL_GAP,
        OP_MUL_GATE,
        OP_MUL_Q,
        OP_SAVE_QSQ,
        OP_MUL_LD,
        OP_SAVE_PLD,
        OP_MUL_RHS,
        OP_SAVE_RHS,
        OP_MUL_DOT,
        OP_JOIN,
        OP_OPEN,
        OP_BREAK,
        OP_FINAL
    } op_t;

    // Jump conditions, tested after the step's action
    typedef enum logic [2:0] {
        JMP_NEVER,
        JMP_ALWAYS,
        JMP_NOT_OPEN,
        JMP_FIRST_EQ_LAST,
        JMP_DSQ_GT_ACC,
        JMP_DSQ_LT_ACC,
        JMP_LHS_GT_RHS,
        JMP_NOT_END
    } jmp_t;

    // Program addresses
    typedef enum logic [5:0] {
        ST_IDLE,
        ST_CHK_OPEN,
        ST_CHK_FIRST,
        ST_DX2,
        ST_DY2,
        ST_SAVE_DSQ,
        ST_GAP_MUL,
        ST_GAP_WAIT,
        ST_GAP_TEST,
        ST_GATE_MUL,
        ST_GATE_WAIT,
        ST_GATE_TEST,
        ST_LX2,
        ST_LY2,
        ST_SAVE_LSQ,
        ST_LXDX,
        ST_LYDY,
        ST_SAVE_ADOT,
        ST_Q_MUL,
        ST_Q_WAIT,
        ST_SAVE_QSQ,
        ST_LD_MUL,
        ST_LD_WAIT,
        ST_SAVE_PLD,
        ST_RHS_MUL,
        ST_RHS_WAIT,
        ST_SAVE_RHS,
        ST_DOT_MUL,
        ST_DOT_WAIT,
        ST_DOT_TEST,
        ST_BREAK,
        ST_JOIN,
        ST_OPEN,
        ST_END_CHK,
        ST_FINAL
    } step_t;

    typedef struct packed {
        hold_t hold;
        op_t   op;
        jmp_t  jmp;
        step_t target;
    } ctl_word_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic in_valid;
        logic mul_busy;
        logic out_full;
        logic open;
        logic first_eq_last;
        logic dsq_gt_acc;
        logic dsq_lt_acc;
        logic lhs_gt_rhs;
        logic end_flag;
    } splc_stat_t;

    function automatic ctl_word_t cw_make(hold_t h, op_t o, jmp_t j, step_t t);
        ctl_word_t w;
        w.hold   = h;
        w.op     = o;
        w.jmp    = j;
        w.target = t;
        return w;
    endfunction

    // Microcode program
    function automatic ctl_word_t ucode_rom(step_t pc);
        ctl_word_t w;
        w = cw_make(HOLD_NONE, OP_NONE, JMP_NEVER, ST_IDLE);
        unique case (pc)
            ST_IDLE:      w = cw_make(HOLD_NO_INPUT, OP_ACCEPT, JMP_NEVER, ST_IDLE);
            ST_CHK_OPEN:  w = cw_make(HOLD_NONE, OP_NONE, JMP_NOT_OPEN, ST_OPEN);
            ST_CHK_FIRST: w = cw_make(HOLD_NONE, OP_NONE, JMP_FIRST_EQ_LAST, ST_JOIN);
            ST_DX2:       w = cw_make(HOLD_NONE, OP_MAC_DXDX, JMP_NEVER, ST_IDLE);
            ST_DY2:       w = cw_make(HOLD_NONE, OP_MAC_DYDY, JMP_NEVER, ST_IDLE);
            ST_SAVE_DSQ:  w = cw_make(HOLD_NONE, OP_SAVE_DSQ, JMP_NEVER, ST_IDLE);
            ST_GAP_MUL:   w = cw_make(HOLD_NONE, OP_MUL_GAP, JMP_NEVER, ST_IDLE);
            ST_GAP_WAIT:  w = cw_make(HOLD_MUL_BUSY, OP_NONE, JMP_NEVER, ST_IDLE);
            ST_GAP_TEST:  w = cw_make(HOLD_NONE, OP_NONE, JMP_DSQ_GT_ACC, ST_BREAK);
            ST_GATE_MUL:  w = cw_make(HOLD_NONE, OP_MUL_GATE, JMP_NEVER, ST_IDLE);
            ST_GATE_WAIT: w = cw_make(HOLD_MUL_BUSY, OP_NONE, JMP_NEVER, ST_IDLE);
            ST_GATE_TEST: w = cw_make(HOLD_NONE, OP_NONE, JMP_DSQ_LT_ACC, ST_JOIN);
            ST_LX2:       w = cw_make(HOLD_NONE, OP_MAC_LXLX, JMP_NEVER, ST_IDLE);
            ST_LY2:       w = cw_make(HOLD_NONE, OP_MAC_LYLY, JMP_NEVER, ST_IDLE);
            ST_SAVE_LSQ:  w = cw_make(HOLD_NONE, OP_SAVE_LSQ, JMP_NEVER, ST_IDLE);
            ST_LXDX:      w = cw_make(HOLD_NONE, OP_MAC_LXDX, JMP_NEVER, ST_IDLE);
            ST_LYDY:      w = cw_make(HOLD_NONE, OP_MAC_LYDY, JMP_NEVER, ST_IDLE);
            ST_SAVE_ADOT: w = cw_make(HOLD_NONE, OP_SAVE_ADOT, JMP_NEVER, ST_IDLE);
            ST_Q_MUL:     w = cw_make(HOLD_NONE, OP_MUL_Q, JMP_NEVER, ST_IDLE);
            ST_Q_WAIT:    w = cw_make(HOLD_MUL_BUSY, OP_NONE, JMP_NEVER, ST_IDLE);
            ST_SAVE_QSQ:  w = cw_make(HOLD_NONE, OP_SAVE_QSQ, JMP_NEVER, ST_IDLE);
            ST_LD_MUL:    w = cw_make(HOLD_NONE, OP_MUL_LD, JMP_NEVER, ST_IDLE);
            ST_LD_WAIT:   w = cw_make(HOLD_MUL_BUSY, OP_NONE, JMP_NEVER, ST_IDLE);
            ST_SAVE_PLD:  w = cw_make(HOLD_NONE, OP_SAVE_PLD, JMP_NEVER, ST_IDLE);
            ST_RHS_MUL:   w = cw_make(HOLD_NONE, OP_MUL_RHS, JMP_NEVER, ST_IDLE);
            ST_RHS_WAIT:  w = cw_make(HOLD_MUL_BUSY, OP_NONE, JMP_NEVER, ST_IDLE);
            ST_SAVE_RHS:  w = cw_make(HOLD_NONE, OP_SAVE_RHS, JMP_NEVER, ST_IDLE);
            ST_DOT_MUL:   w = cw_make(HOLD_NONE, OP_MUL_DOT, JMP_NEVER, ST_IDLE);
            ST_DOT_WAIT:  w = cw_make(HOLD_MUL_BUSY, OP_NONE, JMP_NEVER, ST_IDLE);
            // direction test failing falls through into the break step
            ST_DOT_TEST:  w = cw_make(HOLD_NONE, OP_NONE, JMP_LHS_GT_RHS, ST_JOIN);
            ST_BREAK:     w = cw_make(HOLD_OUT_FULL, OP_BREAK, JMP_ALWAYS, ST_END_CHK);
            ST_JOIN:      w = cw_make(HOLD_NONE, OP_JOIN, JMP_ALWAYS, ST_END_CHK);
            ST_OPEN:      w = cw_make(HOLD_NONE, OP_OPEN, JMP_NEVER, ST_IDLE);
            ST_END_CHK:   w = cw_make(HOLD_NONE, OP_NONE, JMP_NOT_END, ST_IDLE);
            ST_FINAL:     w = cw_make(HOLD_OUT_FULL, OP_FINAL, JMP_ALWAYS, ST_IDLE);
            default:      w = cw_make(HOLD_NONE, OP_NONE, JMP_ALWAYS, ST_IDLE);
        endcase
        return w;
    endfunction

endpackage

// File: rtl/splc_in_if.sv
// ----------------------------------------------------------------------------
// splc_in_if
// Scan point channel: one point per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface splc_in_if
    import splc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         scan_end;

    modport source (output valid, output point_x, output point_y, output scan_end,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input scan_end,
                    output ready);

endinterface

// File: rtl/splc_out_if.sv
// ----------------------------------------------------------------------------
// splc_out_if
// Segment channel: one line segment per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface splc_out_if
    import splc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] seg_start_x;
    logic signed [COORD_BITS-1:0] seg_start_y;
    logic signed [COORD_BITS-1:0] seg_end_x;
    logic signed [COORD_BITS-1:0] seg_end_y;
    logic                         final_segment;

    modport source (output valid, output seg_start_x, output seg_start_y,
                    output seg_end_x, output seg_end_y, output final_segment,
                    input ready);
    modport sink   (input valid, input seg_start_x, input seg_start_y,
                    input seg_end_x, input seg_end_y, input final_segment,
                    output ready);

endinterface

// File: rtl/splc_seq.sv
// ----------------------------------------------------------------------------
// splc_seq
// Microcode sequencer: step counter, program table, hold and jump logic.
// ----------------------------------------------------------------------------
module splc_seq
    import splc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  splc_stat_t stat,
    output ctl_word_t  cw,
    output logic       fire,
    output step_t      pc
);

    step_t pc_reg;
    step_t pc_next;
    logic  held;
    logic  taken;

    // Current control word
    assign cw   = ucode_rom(pc_reg);
    assign fire = !held;
    assign pc   = pc_reg;

    // Hold, jump and next step
    always_comb
    begin
        unique case (cw.hold)
            HOLD_NONE:     held = 1'b0;
            HOLD_NO_INPUT: held = !stat.in_valid;
            HOLD_MUL_BUSY: held = stat.mul_busy;
            HOLD_OUT_FULL: held = stat.out_full;
            default:       held = 1'b0;
        endcase

        unique case (cw.jmp)
            JMP_NEVER:         taken = 1'b0;
            JMP_ALWAYS:        taken = 1'b1;
            JMP_NOT_OPEN:      taken = !stat.open;
            JMP_FIRST_EQ_LAST: taken = stat.first_eq_last;
            JMP_DSQ_GT_ACC:    taken = stat.dsq_gt_acc;
            JMP_DSQ_LT_ACC:    taken = stat.dsq_lt_acc;
            JMP_LHS_GT_RHS:    taken = stat.lhs_gt_rhs;
            JMP_NOT_END:       taken = !stat.end_flag;
            default:           taken = 1'b0;
        endcase

        if (held)
        begin
            pc_next = pc_reg;
        end
        else if (taken)
        begin
            pc_next = cw.target;
        end
        else
        begin
            pc_next = step_t'(pc_reg + 1'b1);
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: rtl/splc_bigmul.sv
// ----------------------------------------------------------------------------
// splc_bigmul
// Digit-serial wide multiplier: one 8-bit digit of b per cycle, most
// significant digit first, accumulating into a wide product register.
// ----------------------------------------------------------------------------
module splc_bigmul
    import splc_pkg::*;
#(
    parameter int A_W = 4 * COORD_BITS_DEF + 4,
    parameter int B_W = 40,
    parameter int R_W = 4 * COORD_BITS_DEF + 36
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           busy,
    output logic [R_W-1:0] acc
);

    localparam int NDIG  = B_W / DIGIT_W;
    localparam int CNT_W = $clog2(NDIG + 1);

    logic [A_W-1:0]         a_reg;
    logic [A_W-1:0]         a_next;
    logic [B_W-1:0]         b_reg;
    logic [B_W-1:0]         b_next;
    logic [R_W-1:0]         acc_reg;
    logic [R_W-1:0]         acc_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic [A_W+DIGIT_W-1:0] part;

    // One digit partial product
    assign part = a_reg * b_reg[B_W-1 -: DIGIT_W];

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = CNT_W'(NDIG);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg << DIGIT_W) + R_W'(part);
            b_next   = b_reg << DIGIT_W;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // Operands and product
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

// File: rtl/splc_dpath.sv
// ----------------------------------------------------------------------------
// splc_dpath
// Datapath: cluster endpoints, signed multiply-accumulate, join-test
// operands, configuration registers and the segment output register.
// ----------------------------------------------------------------------------
module splc_dpath
    import splc_pkg::*;
#(
    parameter  int COORD_BITS = COORD_BITS_DEF,
    localparam int SW         = 2 * COORD_BITS + 2,
    localparam int AW         = 4 * COORD_BITS + 4,
    localparam int BW         = DIGIT_W * (((SW > QSQ_W ? SW : QSQ_W) + DIGIT_W - 1) / DIGIT_W),
    localparam int RW         = AW + QSQ_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctl_word_t            cw,
    input  logic                 fire,
    output splc_stat_t           stat,
    splc_in_if.sink              point,
    splc_out_if.source           segment,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    output logic                 mul_start,
    output logic [AW-1:0]        mul_a,
    output logic [BW-1:0]        mul_b,
    input  logic                 mul_busy,
    input  logic [RW-1:0]        mul_acc
);

    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int MW = 2 * DW + 1;

    // Point and cluster registers
    logic signed [CB-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic                 end_reg, end_next;
    logic signed [CB-1:0] first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic signed [CB-1:0] last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic                 open_reg, open_next;

    // Arithmetic registers
    logic signed [MW-1:0] mac_reg, mac_next;
    logic [SW-1:0]        dsq_reg, dsq_next, lsq_reg, lsq_next, adot_reg, adot_next;
    logic [QSQ_W-1:0]     qsq_reg, qsq_next;
    logic [AW-1:0]        pld_reg, pld_next;
    logic [RW-1:0]        rhs_reg, rhs_next;

    // Configuration
    logic [CFG_W-1:0] gap_reg, gap_next, gate_reg, gate_next, sim_reg, sim_next;

    // Output register
    logic signed [CB-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [CB-1:0] ex_reg, ex_next, ey_reg, ey_next;
    logic                 fin_reg, fin_next;
    logic                 oval_reg, oval_next;

    // Combinational helpers
    logic signed [DW-1:0]   dx, dy, lx, ly;
    logic signed [DW-1:0]   mac_a, mac_b;
    logic signed [2*DW-1:0] prod;
    logic                   mac_en, mac_clr;
    logic signed [MW-1:0]   mac_abs;

    // Step vectors
    assign dx = DW'(cur_x_reg) - DW'(last_x_reg);
    assign dy = DW'(cur_y_reg) - DW'(last_y_reg);
    assign lx = DW'(last_x_reg) - DW'(first_x_reg);
    assign ly = DW'(last_y_reg) - DW'(first_y_reg);

    assign prod    = mac_a * mac_b;
    assign mac_abs = mac_reg[MW-1] ? -mac_reg : mac_reg;

    // Handshake and status
    assign point.ready = (cw.op == OP_ACCEPT);

    assign stat.in_valid      = point.valid;
    assign stat.mul_busy      = mul_busy;
    assign stat.out_full      = oval_reg;
    assign stat.open          = open_reg;
    assign stat.first_eq_last = (first_x_reg == last_x_reg) && (first_y_reg == last_y_reg);
    assign stat.dsq_gt_acc    = RW'(dsq_reg) > mul_acc;
    assign stat.dsq_lt_acc    = RW'(dsq_reg) < mul_acc;
    assign stat.lhs_gt_rhs    = {mul_acc[AW-1:0], {QSQ_W{1'b0}}} > rhs_reg;
    assign stat.end_flag      = end_reg;

    // Operand selection for the multiply-accumulate and the wide multiplier
    always_comb
    begin
        mac_en    = 1'b0;
        mac_clr   = 1'b0;
        mac_a     = dx;
        mac_b     = dx;
        mul_start = 1'b0;
        mul_a     = AW'(gap_reg);
        mul_b     = BW'(gap_reg);
        if (fire)
        begin
            unique case (cw.op) inside
                OP_MAC_DXDX:
                begin
                    mac_en  = 1'b1;
                    mac_clr = 1'b1;
                end
                OP_MAC_DYDY:
                begin
                    mac_en = 1'b1;
                    mac_a  = dy;
                    mac_b  = dy;
                end
                OP_MAC_LXLX:
                begin
                    mac_en  = 1'b1;
                    mac_clr = 1'b1;
                    mac_a   = lx;
                    mac_b   = lx;
                end
                OP_MAC_LYLY:
                begin
                    mac_en = 1'b1;
                    mac_a  = ly;
                    mac_b  = ly;
                end
                OP_MAC_LXDX:
                begin
                    mac_en  = 1'b1;
                    mac_clr = 1'b1;
                    mac_a   = lx;
                end
                OP_MAC_LYDY:
                begin
                    mac_en = 1'b1;
                    mac_a  = ly;
                    mac_b  = dy;
                end
                OP_MUL_GAP:
                begin
                    mul_start = 1'b1;
                end
                OP_MUL_GATE:
                begin
                    mul_start = 1'b1;
                    mul_a     = AW'(gate_reg);
                    mul_b     = BW'(gate_reg);
                end
                OP_MUL_Q:
                begin
                    mul_start = 1'b1;
                    mul_a     = AW'(sim_reg);
                    mul_b     = BW'(sim_reg);
                end
                OP_MUL_LD:
                begin
                    mul_start = 1'b1;
                    mul_a     = AW'(lsq_reg);
                    mul_b     = BW'(dsq_reg);
                end
                OP_MUL_RHS:
                begin
                    mul_start = 1'b1;
                    mul_a     = pld_reg;
                    mul_b     = BW'(qsq_reg);
                end
                OP_MUL_DOT:
                begin
                    mul_start = 1'b1;
                    mul_a     = AW'(adot_reg);
                    mul_b     = BW'(adot_reg);
                end
                default:
                begin
                    mac_en = 1'b0;
                end
            endcase
        end
    end

    // Next state of registers
    always_comb
    begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        end_next     = end_reg;
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        open_next    = open_reg;
        mac_next     = mac_reg;
        dsq_next     = dsq_reg;
        lsq_next     = lsq_reg;
        adot_next    = adot_reg;
        qsq_next     = qsq_reg;
        pld_next     = pld_reg;
        rhs_next     = rhs_reg;
        gap_next     = gap_reg;
        gate_next    = gate_reg;
        sim_next     = sim_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        ex_next      = ex_reg;
        ey_next      = ey_reg;
        fin_next     = fin_reg;
        oval_next    = oval_reg;

        // segment leaves on an output transfer
        if (segment.ready)
        begin
            oval_next = 1'b0;
        end

        if (mac_en)
        begin
            mac_next = (mac_clr ? MW'(0) : mac_reg) + MW'(prod);
        end

        if (fire)
        begin
            unique case (cw.op) inside
                OP_ACCEPT:
                begin
                    cur_x_next = point.point_x;
                    cur_y_next = point.point_y;
                    end_next   = point.scan_end;
                end
                OP_SAVE_DSQ:  dsq_next  = mac_reg[SW-1:0];
                OP_SAVE_LSQ:  lsq_next  = mac_reg[SW-1:0];
                OP_SAVE_ADOT: adot_next = mac_abs[SW-1:0];
                OP_SAVE_QSQ:  qsq_next  = mul_acc[QSQ_W-1:0];
                OP_SAVE_PLD:  pld_next  = mul_acc[AW-1:0];
                OP_SAVE_RHS:  rhs_next  = mul_acc;
                OP_JOIN:
                begin
                    last_x_next = cur_x_reg;
                    last_y_next = cur_y_reg;
                end
                OP_OPEN:
                begin
                    first_x_next = cur_x_reg;
                    first_y_next = cur_y_reg;
                    last_x_next  = cur_x_reg;
                    last_y_next  = cur_y_reg;
                    open_next    = 1'b1;
                end
                OP_BREAK:
                begin
                    // emit the broken cluster, restart at the new point
                    sx_next      = first_x_reg;
                    sy_next      = first_y_reg;
                    ex_next      = last_x_reg;
                    ey_next      = last_y_reg;
                    fin_next     = 1'b0;
                    oval_next    = 1'b1;
                    first_x_next = cur_x_reg;
                    first_y_next = cur_y_reg;
                    last_x_next  = cur_x_reg;
                    last_y_next  = cur_y_reg;
                end
                OP_FINAL:
                begin
                    sx_next   = first_x_reg;
                    sy_next   = first_y_reg;
                    ex_next   = last_x_reg;
                    ey_next   = last_y_reg;
                    fin_next  = 1'b1;
                    oval_next = 1'b1;
                    open_next = 1'b0;
                end
                default:
                begin
                    end_next = end_reg;
                end
            endcase
        end

        // configuration writes
        if (wr_en)
        begin
            case (wr_index)
                CFG_MAX_GAP:    gap_next  = wr_data;
                CFG_ANGLE_GATE: gate_next = wr_data;
                CFG_LINE_SIM:   sim_next  = wr_data;
                default:        gap_next  = gap_reg;
            endcase
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg    <= 1'b0;
            oval_reg    <= 1'b0;
            gap_reg     <= MAX_GAP_RST;
            gate_reg    <= ANGLE_GATE_RST;
            sim_reg     <= LINE_SIM_RST;
            first_x_reg <= '0;
            first_y_reg <= '0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
        end
        else
        begin
            open_reg    <= open_next;
            oval_reg    <= oval_next;
            gap_reg     <= gap_next;
            gate_reg    <= gate_next;
            sim_reg     <= sim_next;
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        end_reg   <= end_next;
        mac_reg   <= mac_next;
        dsq_reg   <= dsq_next;
        lsq_reg   <= lsq_next;
        adot_reg  <= adot_next;
        qsq_reg   <= qsq_next;
        pld_reg   <= pld_next;
        rhs_reg   <= rhs_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        fin_reg   <= fin_next;
    end

    // Output channel
    assign segment.valid         = oval_reg;
    assign segment.seg_start_x   = sx_reg;
    assign segment.seg_start_y   = sy_reg;
    assign segment.seg_end_x     = ex_reg;
    assign segment.seg_end_y     = ey_reg;
    assign segment.final_segment = fin_reg;

endmodule

// File: rtl/scan_point_line_clustering.sv
// ----------------------------------------------------------------------------
// scan_point_line_clustering
// Rate: one point at a time. A point opens a cluster, joins one whose ends
// coincide, or goes through a full join test of six shared multiplier passes,
// each over ND = ceil(max(2*COORD_BITS+2, 32)/8) digits of its b operand.
// Scan end adds a final emit step; emit steps wait while the segment register is full.
// A segment is valid the cycle after its emit step. Reset is asynchronous,
// active low, and leaves no cluster open and defaults loaded.
// ----------------------------------------------------------------------------
`include "scan_point_line_clustering_assert.svh"

module scan_point_line_clustering
    import splc_pkg::*;
#(
    parameter  int COORD_BITS = COORD_BITS_DEF,
    localparam int SW         = 2 * COORD_BITS + 2,
    localparam int AW         = 4 * COORD_BITS + 4,
    localparam int BW         = DIGIT_W * (((SW > QSQ_W ? SW : QSQ_W) + DIGIT_W - 1) / DIGIT_W),
    localparam int RW         = AW + QSQ_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    splc_in_if.sink              point,
    splc_out_if.source           segment,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data
);

    splc_stat_t    stat;
    ctl_word_t     cw;
    logic          fire;
    step_t         pc;
    logic          mul_start;
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic          mul_busy;
    logic [RW-1:0] mul_acc;

    // Program sequencer
    splc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cw    (cw),
        .fire  (fire),
        .pc    (pc)
    );

    // Shared wide multiplier
    splc_bigmul #(
        .A_W (AW),
        .B_W (BW),
        .R_W (RW)
    ) u_bigmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .acc   (mul_acc)
    );

    // Datapath
    splc_dpath #(
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cw        (cw),
        .fire      (fire),
        .stat      (stat),
        .point     (point),
        .segment   (segment),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .mul_start (mul_start),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_busy  (mul_busy),
        .mul_acc   (mul_acc)
    );

    // Checks
    `SPLC_ASSERT_IMP(a_accept_at_idle, clk, rst_n, point.valid && point.ready, pc == ST_IDLE, "point transfer outside the idle step")
    `SPLC_ASSERT_IMP(a_mul_start_free, clk, rst_n, mul_start, !mul_busy, "multiplier restarted while busy")
    `SPLC_ASSERT_IMP(a_mul_busy_waits, clk, rst_n, mul_busy, pc == ST_GAP_WAIT || pc == ST_GATE_WAIT || pc == ST_Q_WAIT || pc == ST_LD_WAIT || pc == ST_RHS_WAIT || pc == ST_DOT_WAIT, "multiplier busy outside a wait step")
    `SPLC_ASSERT_NXT(a_no_emit_on_accept, clk, rst_n, point.valid && point.ready, !$rose(segment.valid), "segment loaded right after a point transfer")

endmodule
